// ===== hdl/hds_pkg.sv =====
package hds_pkg;

    // Default sizing of the chain
    localparam int MAX_STEPS_DEF    = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int GAIN_WIDTH  = 16;
    localparam int STEPS_WIDTH = 5;
    localparam int FRAC_BITS   = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // Register indexes (paddr[2])
    localparam logic REG_GAIN  = 1'b0;
    localparam logic REG_STEPS = 1'b1;

    // Register reset values
    localparam logic [GAIN_WIDTH-1:0]  GAIN_RESET  = 16'd16384;
    localparam logic [STEPS_WIDTH-1:0] STEPS_RESET = 5'd16;

    // Fill codes of a cell
    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_ONE   = 2'd1;
    localparam logic [1:0] FILL_MANY  = 2'd2;

    // Control side of one point moving between cells
    typedef struct packed {
        logic valid;
        logic last;
    } t_tok_ctl;

endpackage

// ===== hdl/heat_diffusion_stencil_1d_top.sv =====
// 1-D heat diffusion by explicit FTCS time steps, one cell per time step.
// Input stream (s_axis_*): one spatial point per transaction, tlast on the
// final point of a row. Output stream (m_axis_*): the advanced row, one point
// per transaction, tlast on its final point. Rows may follow back to back.
// Configuration over APB: 0x0 diffusion gain (unsigned Q0.16), 0x4 number of
// time steps (0 acts as 1, values above MAX_STEPS act as MAX_STEPS). Write
// configuration only while no row is in flight.
// Each active cell holds back one point of the row. A point is presented on
// m_axis after the input transaction that releases it: the first cell loads
// at the accepting edge, and the point then passes the output register of
// every further active cell and the top's output register. The row's last
// point also waits in the pending slot of every cell.
// Within a row the input takes one point per cycle unless the chain backs up;
// the last point leaves a flushed point in the first cell's pending slot, which
// holds s_axis_tready low until that point moves on.
// The cell's multiply-round-saturate path is the critical path.
// Reset (synchronous, active low) empties all cells and the output register
// and restores gain 16384 and 16 steps. When the receiver holds tready low
// the output register keeps its point, the chain backs up cell by cell, and
// s_axis_tready drops once the first cell is blocked; nothing is lost.
module heat_diffusion_stencil_1d_top #(
    parameter int MAX_STEPS    = hds_pkg::MAX_STEPS_DEF,
    parameter int SAMPLE_WIDTH = hds_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hds_pkg::APB_AW-1:0]          paddr,
    input  logic [hds_pkg::APB_DW-1:0]          pwdata,
    output logic [hds_pkg::APB_DW-1:0]          prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // [W-1:0] sample_value
    input  logic                                s_axis_tlast,  // last_point
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // [W-1:0] result_value
    output logic                                m_axis_tlast   // row_end
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int IDX_W   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam logic [5:0] MAX_STEPS_6 = 6'(MAX_STEPS);

    logic [hds_pkg::GAIN_WIDTH-1:0]  r_gain;
    logic [hds_pkg::STEPS_WIDTH-1:0] r_steps;
    logic                            r_m_valid;
    logic                            r_m_last;
    logic signed [SAMPLE_WIDTH-1:0]  r_m_data;

    logic                            cfg_wr;
    logic [5:0]                      steps_6;
    logic [5:0]                      tap_6;
    logic [IDX_W-1:0]                tap;
    logic                            skid_free;

    hds_pkg::t_tok_ctl               w_in   [MAX_STEPS];
    hds_pkg::t_tok_ctl               w_out  [MAX_STEPS];
    logic                            w_in_ready [MAX_STEPS];
    logic                            w_dn_ready [MAX_STEPS];
    logic signed [SAMPLE_WIDTH-1:0]  w_in_data  [MAX_STEPS];
    logic signed [SAMPLE_WIDTH-1:0]  w_out_data [MAX_STEPS];

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= hds_pkg::GAIN_RESET;
            r_steps <= hds_pkg::STEPS_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                hds_pkg::REG_GAIN:  r_gain  <= pwdata[hds_pkg::GAIN_WIDTH-1:0];
                hds_pkg::REG_STEPS: r_steps <= pwdata[hds_pkg::STEPS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            hds_pkg::REG_GAIN:  prdata = hds_pkg::APB_DW'(r_gain);
            hds_pkg::REG_STEPS: prdata = hds_pkg::APB_DW'(r_steps);
            default:            prdata = '0;
        endcase
    end

    // Index of the last active cell: clamp steps to 1..MAX_STEPS
    always_comb begin
        steps_6 = 6'(r_steps);
        if (steps_6 == 6'd0) begin
            tap_6 = 6'd0;
        end else if (steps_6 > MAX_STEPS_6) begin
            tap_6 = MAX_STEPS_6 - 6'd1;
        end else begin
            tap_6 = steps_6 - 6'd1;
        end
        tap = tap_6[IDX_W-1:0];
    end

    // Chain of cells; the active tail feeds the output register
    assign w_in[0].valid  = s_axis_tvalid;
    assign w_in[0].last   = s_axis_tlast;
    assign w_in_data[0]   = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign s_axis_tready  = w_in_ready[0];

    genvar k;
    generate
        for (k = 0; k < MAX_STEPS; k++) begin : g_cell
            if (k > 0) begin : g_link
                assign w_in[k].valid = w_out[k-1].valid && (IDX_W'(k) <= tap);
                assign w_in[k].last  = w_out[k-1].last;
                assign w_in_data[k]  = w_out_data[k-1];
            end
            if (k < MAX_STEPS - 1) begin : g_dn
                assign w_dn_ready[k] = (IDX_W'(k) < tap) ? w_in_ready[k+1] :
                                       ((IDX_W'(k) == tap) && skid_free);
            end else begin : g_tail
                assign w_dn_ready[k] = (IDX_W'(k) == tap) && skid_free;
            end

            hds_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_gain      (r_gain),
                .i_in        (w_in[k]),
                .o_in_ready  (w_in_ready[k]),
                .i_in_data   (w_in_data[k]),
                .o_out       (w_out[k]),
                .i_out_ready (w_dn_ready[k]),
                .o_out_data  (w_out_data[k])
            );
        end
    endgenerate

    // Output register
    assign skid_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (skid_free) begin
            r_m_valid <= w_out[tap].valid;
            r_m_last  <= w_out[tap].last;
            r_m_data  <= w_out_data[tap];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = TDATA_W'($unsigned(r_m_data));

endmodule

// ===== hdl/hds_cell.sv =====
module hds_cell #(
    parameter int SAMPLE_WIDTH = hds_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [hds_pkg::GAIN_WIDTH-1:0]      i_gain,
    input  hds_pkg::t_tok_ctl                   i_in,
    output logic                                o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_in_data,
    output hds_pkg::t_tok_ctl                   o_out,
    input  logic                                i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      o_out_data
);

    localparam int LAP_W  = SAMPLE_WIDTH + 2;
    localparam int PROD_W = hds_pkg::GAIN_WIDTH + 1 + LAP_W;
    localparam int TERM_W = PROD_W - hds_pkg::FRAC_BITS;
    localparam int SUM_W  = TERM_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (hds_pkg::FRAC_BITS - 1));

    logic [1:0]                    r_fill;
    logic signed [SAMPLE_WIDTH-1:0] r_older;
    logic signed [SAMPLE_WIDTH-1:0] r_newer;
    logic                          r_out_valid;
    logic                          r_out_last;
    logic signed [SAMPLE_WIDTH-1:0] r_out_data;
    logic                          r_pend_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_pend_data;

    logic                          out_free;
    logic                          accept;
    logic                          emit_a;
    logic signed [LAP_W-1:0]       lap;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      prod_rnd;
    logic signed [TERM_W-1:0]      term;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SAMPLE_WIDTH-1:0] adv;
    logic signed [SAMPLE_WIDTH-1:0] a_data;

    // Handshake: a second (flushed) point waits in the pending slot
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_pend_valid && out_free;
    assign accept     = i_in.valid && o_in_ready;
    assign emit_a     = (r_fill != hds_pkg::FILL_EMPTY);

    // One FTCS update of the held centre point, round half up, saturate
    always_comb begin
        lap      = LAP_W'(r_older) + LAP_W'(i_in_data) - (LAP_W'(r_newer) <<< 1);
        prod     = $signed({1'b0, i_gain}) * lap;
        prod_rnd = prod + ROUND_HALF;
        term     = prod_rnd[PROD_W-1:hds_pkg::FRAC_BITS];
        sum      = SUM_W'(r_newer) + SUM_W'(term);
        if (sum > SAT_HI) begin
            adv = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (sum < SAT_LO) begin
            adv = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            adv = sum[SAMPLE_WIDTH-1:0];
        end
        // first point of a row is a boundary and passes unchanged
        a_data = (r_fill == hds_pkg::FILL_ONE) ? r_newer : adv;
    end

    // Window, fill count and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= hds_pkg::FILL_EMPTY;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_pend_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out_data   <= r_pend_data;
                    r_out_last   <= 1'b1;
                    r_pend_valid <= 1'b0;
                end else if (accept && (emit_a || i_in.last)) begin
                    r_out_valid  <= 1'b1;
                    r_out_data   <= emit_a ? a_data : i_in_data;
                    r_out_last   <= !emit_a;
                    r_pend_valid <= emit_a && i_in.last;
                end else begin
                    r_out_valid  <= 1'b0;
                end
            end
            if (accept) begin
                r_older     <= r_newer;
                r_newer     <= i_in_data;
                r_pend_data <= i_in_data;
                if (i_in.last) begin
                    r_fill <= hds_pkg::FILL_EMPTY;
                end else if (emit_a) begin
                    r_fill <= hds_pkg::FILL_MANY;
                end else begin
                    r_fill <= hds_pkg::FILL_ONE;
                end
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.last  = r_out_last;
    assign o_out_data  = r_out_data;

    // A pending point only ever sits behind a full output register
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("pending point without output point");

    // Fill count never takes the unused code
    a_fill_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("bad fill count");

    // End of row empties the window
    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last) |=> (r_fill == hds_pkg::FILL_EMPTY))
        else $error("window not cleared at row end");

    // A last point with a held point ahead of it leaves a pending flush
    a_flush_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last && emit_a) |=> r_pend_valid)
        else $error("flushed point lost");

endmodule
